/* rtl/kpr_pkg.sv */
// ----------------------------------------------------------------------------
// Keyboard poll and rollover package
// Shared constants, protocol codes and types for the six-key report builder.
// ----------------------------------------------------------------------------
package kpr_pkg;

  // Scancode map geometry.
  localparam int SCANCODES     = 128;
  localparam int SCAN_W        = $clog2(SCANCODES);
  localparam int SLOT_IDX_W    = 3;
  localparam logic [SLOT_IDX_W-1:0] NO_SLOT = 3'd7;

  // Report geometry: six slot ports, of which KEY_SLOTS are in use.
  localparam int SLOT_PORTS    = 6;
  localparam int KEY_SLOTS_DEF = 6;

  // Completion kinds on the input channel.
  localparam logic REQ_WRITE_DONE = 1'b0;
  localparam logic REQ_READ_DONE  = 1'b1;

  // Next action on the result channel.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Keyboard command bytes.
  localparam logic [7:0] OPC_NONE       = 8'h00;
  localparam logic [7:0] OPC_MODEL      = 8'h16;
  localparam logic [7:0] OPC_TRANSITION = 8'h10;
  localparam logic [7:0] OPC_INSTANT    = 8'h14;

  // Special transition bytes.
  localparam logic [7:0] BYTE_NULL   = 8'h7b;
  localparam logic [7:0] BYTE_KEYPAD = 8'h79;

  // Protocol phase, one-hot.
  typedef enum logic [3:0] {
    PH_MODEL_WR = 4'b0001,
    PH_MODEL_RD = 4'b0010,
    PH_TRANS_WR = 4'b0100,
    PH_TRANS_RD = 4'b1000
  } phase_t;

  // Write into the scancode-to-slot map.
  typedef struct packed {
    logic                  en;
    logic [SCAN_W-1:0]     addr;
    logic [SLOT_IDX_W-1:0] slot;
  } map_wr_t;

  // Control part of one result.
  typedef struct packed {
    logic       valid;
    logic       action;
    logic [7:0] cmd;
    logic       send;
  } res_ctl_t;

endpackage

/* rtl/kpr_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module kpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while the read is not enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/kpr_slot_map.sv */
// ----------------------------------------------------------------------------
// Scancode slot map
// Remembers the report slot of each held scancode, with valid bits for the
// reset state and a bypass for a write that meets a read of the same entry.
// ----------------------------------------------------------------------------
module kpr_slot_map
  import kpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [SCAN_W-1:0]     rd_addr,
  input  map_wr_t               wr,
  output logic [SLOT_IDX_W-1:0] held
);

  logic                  vld_r [SCANCODES];
  logic                  hit;
  logic                  fwd_r;
  logic [SLOT_IDX_W-1:0] fwd_slot_r;
  logic                  ent_vld_r;
  logic [SLOT_IDX_W-1:0] ram_q;

  kpr_ram #(
    .WIDTH(SLOT_IDX_W),
    .DEPTH(SCANCODES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr.en),
    .wr_addr(wr.addr),
    .wr_data(wr.slot),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  // A write in the same cycle as the lookup of the same scancode wins.
  assign hit = wr.en && (wr.addr == rd_addr);

  // Valid bits: an entry never written reads as not pressed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SCANCODES; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Lookup side information, captured with the RAM read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r     <= 1'b0;
      ent_vld_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r     <= hit;
      ent_vld_r <= vld_r[rd_addr] || hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_slot_r <= wr.slot;
    end
  end

  // Slot currently held by the scancode of the item in the work stage.
  always_comb begin
    if (fwd_r) begin
      held = fwd_slot_r;
    end else if (ent_vld_r) begin
      held = ram_q;
    end else begin
      held = NO_SLOT;
    end
  end

endmodule

/* rtl/kpr_engine.sv */
// ----------------------------------------------------------------------------
// Poll and rollover engine
// Protocol phase tracking, keypad prefix handling and report slot updates
// for the item in the work stage.
// ----------------------------------------------------------------------------
module kpr_engine
  import kpr_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  logic                  advance,
  input  logic                  req_type,
  input  logic [7:0]            status,
  input  logic [7:0]            data,
  input  logic [7:0]            key_code,
  input  logic [SLOT_IDX_W-1:0] held,
  output res_ctl_t              res,
  output logic [7:0]            slots_nxt [KEY_SLOTS],
  output map_wr_t               map_wr
);

  phase_t     phase_r, phase_nxt;
  logic       kp_r, kp_nxt;
  logic [7:0] slots_r [KEY_SLOTS];
  logic       want;
  logic       go;
  logic       found;
  map_wr_t    wr_c;

  // The phase decides which completion kind is expected.
  assign want = ((phase_r == PH_MODEL_RD) || (phase_r == PH_TRANS_RD)) ?
                REQ_READ_DONE : REQ_WRITE_DONE;
  assign go   = item_valid && advance && (req_type == want);

  // Next state and result for the current item.
  always_comb begin
    phase_nxt  = phase_r;
    kp_nxt     = kp_r;
    slots_nxt  = slots_r;
    res.valid  = go;
    res.action = ACT_WRITE;
    res.cmd    = OPC_NONE;
    res.send   = 1'b0;
    wr_c.en    = 1'b0;
    wr_c.addr  = data[SCAN_W-1:0];
    wr_c.slot  = NO_SLOT;
    found      = 1'b0;
    if (status != 8'h00) begin
      res.cmd   = OPC_MODEL;
      phase_nxt = PH_MODEL_WR;
    end else begin
      unique case (phase_r)
        PH_MODEL_WR: begin
          res.action = ACT_READ;
          phase_nxt  = PH_MODEL_RD;
        end
        PH_MODEL_RD: begin
          res.cmd   = OPC_TRANSITION;
          phase_nxt = PH_TRANS_WR;
        end
        PH_TRANS_WR: begin
          res.action = ACT_READ;
          phase_nxt  = PH_TRANS_RD;
        end
        PH_TRANS_RD: begin
          phase_nxt = PH_TRANS_WR;
          if (data == BYTE_NULL) begin
            res.cmd = OPC_TRANSITION;
          end else if (data == BYTE_KEYPAD) begin
            kp_nxt  = 1'b1;
            res.cmd = OPC_INSTANT;
          end else begin
            res.cmd  = OPC_TRANSITION;
            res.send = 1'b1;
            if (kp_r) begin
              // The byte after a keypad prefix is dropped.
              kp_nxt = 1'b0;
            end else if (data[7]) begin
              // Release: free the slot and forget the scancode.
              if (held != NO_SLOT) begin
                for (int i = 0; i < KEY_SLOTS; i++) begin
                  if (held == SLOT_IDX_W'(i)) begin
                    slots_nxt[i] = 8'h00;
                  end
                end
                wr_c.en = 1'b1;
              end
            end else if (held == NO_SLOT) begin
              // Press: take the first empty slot, if any.
              for (int i = 0; i < KEY_SLOTS; i++) begin
                if (!found && (slots_r[i] == 8'h00)) begin
                  found        = 1'b1;
                  slots_nxt[i] = key_code;
                  wr_c.en      = 1'b1;
                  wr_c.slot    = SLOT_IDX_W'(i);
                end
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_MODEL_WR;
        end
      endcase
    end
  end

  // The map is written only when the item is really taken.
  always_comb begin
    map_wr    = wr_c;
    map_wr.en = wr_c.en && go;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MODEL_WR;
      kp_r    <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slots_r[i] <= 8'h00;
      end
    end else if (go) begin
      phase_r <= phase_nxt;
      kp_r    <= kp_nxt;
      slots_r <= slots_nxt;
    end
  end

endmodule

/* rtl/keyboard_poll_and_rollover_core.sv */
// ----------------------------------------------------------------------------
// Keyboard poll and rollover core
// Builds a six-key report from completion events of a polled keyboard link.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_*) takes one link completion per transfer: the kind
// (write or read done), its status, the byte read and the usage code that
// the caller has already looked up for that byte's scancode.
// The result channel (out_*) gives, for each completion that matches the
// expected kind, the next link action, the command byte to write and the
// six report slots; out_report_send marks a key event to report now.
// A completion of the wrong kind is absorbed and gives no result.
// The input transfer loads the input register together with the registered
// scancode map read, and the update then goes into the output register once
// the output register is free. One item is accepted per cycle while the
// output is not stalled; the scancode map read-modify-write sets that rate.
// When the receiver stalls, the result holds and the input register holds;
// an empty input register still takes one more item before in_ready drops.
// Reset clears the phase to await the model-command write, empties all
// report slots and marks every scancode as not pressed at once.
// ----------------------------------------------------------------------------
module keyboard_poll_and_rollover_core
  import kpr_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [7:0] in_status,
  input  logic [7:0] in_data,
  input  logic [7:0] in_key_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_next_action,
  output logic [7:0] out_command_byte,
  output logic       out_report_send,
  output logic [7:0] out_slot0,
  output logic [7:0] out_slot1,
  output logic [7:0] out_slot2,
  output logic [7:0] out_slot3,
  output logic [7:0] out_slot4,
  output logic [7:0] out_slot5
);

  logic                  in_fire;
  logic                  adv;
  logic                  s1_valid_r;
  logic                  s1_req_type_r;
  logic [7:0]            s1_status_r;
  logic [7:0]            s1_data_r;
  logic [7:0]            s1_key_code_r;
  logic [SLOT_IDX_W-1:0] held;
  map_wr_t               map_wr;
  res_ctl_t              res;
  logic [7:0]            slots_nxt [KEY_SLOTS];
  logic                  out_valid_r;
  logic                  out_action_r;
  logic [7:0]            out_cmd_r;
  logic                  out_send_r;
  logic [7:0]            out_slot_r [SLOT_PORTS];

  // Handshake: the work stage moves when the output register is free.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_type_r <= in_req_type;
      s1_status_r   <= in_status;
      s1_data_r     <= in_data;
      s1_key_code_r <= in_key_code;
    end
  end

  // Scancode map lookup, issued on the input transfer.
  kpr_slot_map u_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_fire),
    .rd_addr(in_data[SCAN_W-1:0]),
    .wr     (map_wr),
    .held   (held)
  );

  // Phase and report update.
  kpr_engine #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(s1_valid_r),
    .advance   (adv),
    .req_type  (s1_req_type_r),
    .status    (s1_status_r),
    .data      (s1_data_r),
    .key_code  (s1_key_code_r),
    .held      (held),
    .res       (res),
    .slots_nxt (slots_nxt),
    .map_wr    (map_wr)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_action_r <= res.action;
      out_cmd_r    <= res.cmd;
      out_send_r   <= res.send;
    end
  end

  // Slot ports above the configured slot count read as empty.
  for (genvar g = 0; g < SLOT_PORTS; g++) begin : g_slot
    if (g < KEY_SLOTS) begin : g_used
      always_ff @(posedge clk) begin
        if (adv && res.valid) begin
          out_slot_r[g] <= slots_nxt[g];
        end
      end
    end else begin : g_unused
      always_ff @(posedge clk) begin
        out_slot_r[g] <= 8'h00;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_action  = out_action_r;
  assign out_command_byte = out_cmd_r;
  assign out_report_send  = out_send_r;
  assign out_slot0        = out_slot_r[0];
  assign out_slot1        = out_slot_r[1];
  assign out_slot2        = out_slot_r[2];
  assign out_slot3        = out_slot_r[3];
  assign out_slot4        = out_slot_r[4];
  assign out_slot5        = out_slot_r[5];

endmodule

/* rtl/kpr_checker.sv */
// ----------------------------------------------------------------------------
// Poll and rollover port checker
// Watches the top level's ports for result consistency and stall behavior.
// ----------------------------------------------------------------------------
module kpr_checker
  import kpr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_next_action,
  input logic [7:0] out_command_byte,
  input logic       out_report_send
);

  // A read carries no command byte.
  a_read_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_next_action == ACT_READ) |-> out_command_byte == OPC_NONE)
    else $error("read result carries a command byte");

  // A write carries one of the known commands.
  a_write_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_next_action == ACT_WRITE) |->
      (out_command_byte == OPC_MODEL) || (out_command_byte == OPC_TRANSITION) ||
      (out_command_byte == OPC_INSTANT))
    else $error("write result carries an unknown command");

  // A key report goes out only together with the next transition poll.
  a_send_poll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_send |->
      (out_next_action == ACT_WRITE) && (out_command_byte == OPC_TRANSITION))
    else $error("report sent outside a transition poll");

  // A stalled result stays in place.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command_byte) &&
      $stable(out_next_action))
    else $error("stalled result changed");

  // No result right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind keyboard_poll_and_rollover_core kpr_checker u_kpr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_next_action (out_next_action),
  .out_command_byte(out_command_byte),
  .out_report_send (out_report_send)
);
